// ===== src/polynomial_taylor_shift_defines.svh =====
`ifndef POLYNOMIAL_TAYLOR_SHIFT_DEFINES_SVH
`define POLYNOMIAL_TAYLOR_SHIFT_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define PTS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/pts_pkg.sv =====
package pts_pkg;

  // polynomial degree, fixed by the coefficient ports
  localparam int Degree           = 5;
  // one cell per horner step
  localparam int NumCells         = Degree * (Degree + 1) / 2;
  localparam int ShiftWidth       = 24;
  localparam int FracBits         = 16;
  // accumulator headroom above the coefficient width
  localparam int AccGuard         = 7;
  localparam int CoefWidthDefault = 32;

  typedef struct packed {
    logic valid;
    logic ovf;
  } pts_ctrl_t;

  // coefficient index updated by cell n of the repeated horner schedule
  function automatic int cell_index(input int n);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int i = 0; i < Degree; i++) begin
      for (int k = Degree - 1; k >= i; k--) begin
        if (cnt == n) begin
          res = k;
        end
        cnt++;
      end
    end
    return res;
  endfunction

endpackage

// ===== src/polynomial_taylor_shift.sv =====
// Taylor shift of a degree-5 polynomial: returns the coefficients of p(t+s) from those of p(t),
// computed by the repeated Horner scheme in Q16.16 with a 7-bit-wider saturating accumulator,
// final results clamped to the coefficient range and overflow raised on any clamp. One request
// is taken per clock while in_stall_o is low; nothing is kept between requests. The datapath
// is a row of 15 cells, one per Horner step, each with a multiply stage and an accumulate
// stage, so a request passes 31 registers (two per cell plus the output register), the first
// loaded at the accepting edge. The output register has a one-entry skid behind it: while the
// result waits on out_stall_i the block still takes requests, and in_stall_o rises only once the
// skid entry is occupied (it is driven from that register alone, with no combinational path from
// out_stall_i).
module polynomial_taylor_shift import pts_pkg::*; #(
  parameter int CoefWidth = CoefWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ShiftWidth-1:0]       shift_time_i,
  input  logic signed [CoefWidth-1:0] coef_p0_i,
  input  logic signed [CoefWidth-1:0] coef_p1_i,
  input  logic signed [CoefWidth-1:0] coef_p2_i,
  input  logic signed [CoefWidth-1:0] coef_p3_i,
  input  logic signed [CoefWidth-1:0] coef_p4_i,
  input  logic signed [CoefWidth-1:0] coef_p5_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoefWidth-1:0] shifted_p0_o,
  output logic signed [CoefWidth-1:0] shifted_p1_o,
  output logic signed [CoefWidth-1:0] shifted_p2_o,
  output logic signed [CoefWidth-1:0] shifted_p3_o,
  output logic signed [CoefWidth-1:0] shifted_p4_o,
  output logic signed [CoefWidth-1:0] shifted_p5_o,
  output logic                        overflow_o
);

  localparam int AccBits = CoefWidth + AccGuard;

  // chain links: entry n feeds cell n
  pts_ctrl_t                    chain_ctrl  [NumCells+1];
  logic [ShiftWidth-1:0]        chain_shift [NumCells];
  logic [Degree:0][AccBits-1:0] chain_coef  [NumCells+1];
  logic                         chain_en;

  logic [Degree:0][CoefWidth-1:0] shifted;

  // request enters the chain with coefficients widened to the accumulator
  assign chain_ctrl[0].valid = in_valid_i;
  assign chain_ctrl[0].ovf   = 1'b0;
  assign chain_shift[0]      = shift_time_i;
  assign chain_coef[0][0]    = {{AccGuard{coef_p0_i[CoefWidth-1]}}, coef_p0_i};
  assign chain_coef[0][1]    = {{AccGuard{coef_p1_i[CoefWidth-1]}}, coef_p1_i};
  assign chain_coef[0][2]    = {{AccGuard{coef_p2_i[CoefWidth-1]}}, coef_p2_i};
  assign chain_coef[0][3]    = {{AccGuard{coef_p3_i[CoefWidth-1]}}, coef_p3_i};
  assign chain_coef[0][4]    = {{AccGuard{coef_p4_i[CoefWidth-1]}}, coef_p4_i};
  assign chain_coef[0][5]    = {{AccGuard{coef_p5_i[CoefWidth-1]}}, coef_p5_i};

  // the whole chain moves together; it halts only while the skid entry is full
  assign in_stall_o = !chain_en;

  for (genvar n = 0; n < NumCells; n++) begin : g_cell
    if (n < NumCells - 1) begin : g_mid
      pts_cell #(
        .CoefWidth (CoefWidth),
        .Step      (n)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (chain_en),
        .ctrl_i  (chain_ctrl[n]),
        .shift_i (chain_shift[n]),
        .coef_i  (chain_coef[n]),
        .ctrl_o  (chain_ctrl[n+1]),
        .shift_o (chain_shift[n+1]),
        .coef_o  (chain_coef[n+1])
      );
    end else begin : g_last
      // last step: the shift is no longer needed downstream
      pts_cell #(
        .CoefWidth (CoefWidth),
        .Step      (n)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (chain_en),
        .ctrl_i  (chain_ctrl[n]),
        .shift_i (chain_shift[n]),
        .coef_i  (chain_coef[n]),
        .ctrl_o  (chain_ctrl[n+1]),
        .shift_o (),
        .coef_o  (chain_coef[n+1])
      );
    end
  end

  // final clamp, output register and skid
  pts_out #(
    .CoefWidth (CoefWidth)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (chain_ctrl[NumCells]),
    .coef_i      (chain_coef[NumCells]),
    .en_o        (chain_en),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .shifted_o   (shifted),
    .overflow_o  (overflow_o)
  );

  assign shifted_p0_o = shifted[0];
  assign shifted_p1_o = shifted[1];
  assign shifted_p2_o = shifted[2];
  assign shifted_p3_o = shifted[3];
  assign shifted_p4_o = shifted[4];
  assign shifted_p5_o = shifted[5];

endmodule

// ===== src/pts_cell.sv =====
module pts_cell import pts_pkg::*; #(
  parameter int CoefWidth = CoefWidthDefault,
  parameter int Step = 0,
  localparam int AccBits = CoefWidth + AccGuard
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pts_ctrl_t                     ctrl_i,
  input  logic [ShiftWidth-1:0]         shift_i,
  input  logic [Degree:0][AccBits-1:0]  coef_i,
  output pts_ctrl_t                     ctrl_o,
  output logic [ShiftWidth-1:0]         shift_o,
  output logic [Degree:0][AccBits-1:0]  coef_o
);

  localparam int K        = cell_index(Step);
  localparam int HiBits   = AccBits - FracBits;
  localparam int ProdBits = HiBits + ShiftWidth + 1;
  localparam int LoBits   = ShiftWidth + FracBits;
  localparam int RndBits  = LoBits + 1 - FracBits;
  localparam int SumBits  = ProdBits + 2;
  localparam logic [LoBits:0] RoundHalf = (LoBits + 1)'(1) << (FracBits - 1);

  // stage a: partial products of s times b[k+1]
  logic signed [ProdBits-1:0] shift_ext, hi_ext, hi_prod;
  logic [LoBits-1:0]          lo_prod;

  pts_ctrl_t                  a_ctrl_q;
  logic [ShiftWidth-1:0]      a_shift_q;
  logic [Degree:0][AccBits-1:0] a_coef_q;
  logic signed [ProdBits-1:0] a_hi_q;
  logic [LoBits-1:0]          a_lo_q;

  assign shift_ext = {{(ProdBits - ShiftWidth){1'b0}}, shift_i};
  assign hi_ext    = {{(ProdBits - HiBits){coef_i[K+1][AccBits-1]}},
                      coef_i[K+1][AccBits-1:FracBits]};
  assign hi_prod   = shift_ext * hi_ext;
  assign lo_prod   = LoBits'(shift_i) * LoBits'(coef_i[K+1][FracBits-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q <= '0;
    end else if (en_i) begin
      a_ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_shift_q <= shift_i;
      a_coef_q  <= coef_i;
      a_hi_q    <= hi_prod;
      a_lo_q    <= lo_prod;
    end
  end

  // stage b: round, accumulate into b[k], clamp to the accumulator range
  logic [LoBits:0]            lo_sum;
  logic [RndBits-1:0]         lo_rnd;
  logic signed [SumBits-1:0]  sum;
  logic                       sat_pos, sat_neg;
  logic [AccBits-1:0]         acc_d;
  pts_ctrl_t                  ctrl_d;
  logic [Degree:0][AccBits-1:0] coef_d;

  assign lo_sum = {1'b0, a_lo_q} + RoundHalf;
  assign lo_rnd = lo_sum[LoBits:FracBits];

  assign sum = {{(SumBits - ProdBits){a_hi_q[ProdBits-1]}}, a_hi_q}
             + {{(SumBits - RndBits){1'b0}}, lo_rnd}
             + {{(SumBits - AccBits){a_coef_q[K][AccBits-1]}}, a_coef_q[K]};

  assign sat_pos = !sum[SumBits-1] && (|sum[SumBits-2:AccBits-1]);
  assign sat_neg = sum[SumBits-1] && !(&sum[SumBits-2:AccBits-1]);

  always_comb begin
    priority if (sat_pos) begin
      acc_d = {1'b0, {(AccBits - 1){1'b1}}};
    end else if (sat_neg) begin
      acc_d = {1'b1, {(AccBits - 1){1'b0}}};
    end else begin
      acc_d = sum[AccBits-1:0];
    end
    coef_d       = a_coef_q;
    coef_d[K]    = acc_d;
    ctrl_d.valid = a_ctrl_q.valid;
    ctrl_d.ovf   = a_ctrl_q.ovf | sat_pos | sat_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shift_o <= a_shift_q;
      coef_o  <= coef_d;
    end
  end

endmodule

// ===== src/pts_out.sv =====
`include "polynomial_taylor_shift_defines.svh"

module pts_out import pts_pkg::*; #(
  parameter int CoefWidth = CoefWidthDefault,
  localparam int AccBits = CoefWidth + AccGuard
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pts_ctrl_t                      ctrl_i,
  input  logic [Degree:0][AccBits-1:0]   coef_i,
  output logic                           en_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [Degree:0][CoefWidth-1:0] shifted_o,
  output logic                           overflow_o
);

  // final clamp to the coefficient range
  logic [Degree:0][CoefWidth-1:0] sat_coef;
  logic [Degree:0]                sat_hit;
  logic                           sat_ovf;

  always_comb begin
    for (int k = 0; k <= Degree; k++) begin
      sat_hit[k] = 1'b0;
      if (!coef_i[k][AccBits-1] && (|coef_i[k][AccBits-2:CoefWidth-1])) begin
        sat_coef[k] = {1'b0, {(CoefWidth - 1){1'b1}}};
        sat_hit[k]  = 1'b1;
      end else if (coef_i[k][AccBits-1] && !(&coef_i[k][AccBits-2:CoefWidth-1])) begin
        sat_coef[k] = {1'b1, {(CoefWidth - 1){1'b0}}};
        sat_hit[k]  = 1'b1;
      end else begin
        sat_coef[k] = coef_i[k][CoefWidth-1:0];
      end
    end
  end

  assign sat_ovf = ctrl_i.ovf | (|sat_hit);

  // output register plus one skid entry
  logic                           out_valid_q, out_valid_d;
  logic [Degree:0][CoefWidth-1:0] out_coef_q, out_coef_d;
  logic                           out_ovf_q, out_ovf_d;
  logic                           skid_valid_q, skid_valid_d;
  logic [Degree:0][CoefWidth-1:0] skid_coef_q, skid_coef_d;
  logic                           skid_ovf_q, skid_ovf_d;
  logic                           out_free, new_item;

  assign en_o     = !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign new_item = ctrl_i.valid && en_o;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_coef_d   = out_coef_q;
    out_ovf_d    = out_ovf_q;
    skid_valid_d = skid_valid_q;
    skid_coef_d  = skid_coef_q;
    skid_ovf_d   = skid_ovf_q;
    priority if (skid_valid_q) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_coef_d   = skid_coef_q;
        out_ovf_d    = skid_ovf_q;
        skid_valid_d = 1'b0;
      end
    end else if (new_item) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_coef_d  = sat_coef;
        out_ovf_d   = sat_ovf;
      end else begin
        skid_valid_d = 1'b1;
        skid_coef_d  = sat_coef;
        skid_ovf_d   = sat_ovf;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_coef_q  <= out_coef_d;
    out_ovf_q   <= out_ovf_d;
    skid_coef_q <= skid_coef_d;
    skid_ovf_q  <= skid_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign shifted_o   = out_coef_q;
  assign overflow_o  = out_ovf_q;

  `PTS_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid holds a request while output is empty")
  `PTS_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i), "skid filled without a stalled output")
  `PTS_ASSERT(a_no_drop, new_item && out_valid_q && out_stall_i |=> skid_valid_q, "request from chain lost at a stalled output")
  `PTS_ASSERT(a_skid_drain, skid_valid_q && !out_stall_i |=> out_valid_q && !skid_valid_q, "skid did not drain into the output")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pts_pkg::*;

  localparam int CoefW       = CoefWidthDefault;
  // accumulator width of the datapath, coefficient width plus guard bits
  localparam int AccBits     = CoefW + AccGuard;
  localparam int NumRandom   = 1536;
  // idle-free tail of the run, counted in pending requests
  localparam int CalmTail    = 120;
  // cycles without any handshake before the run is abandoned
  localparam int StuckLimit  = 4000;
  // pipeline depth plus margin, used for the final drain
  localparam int DrainCycles = 48;

  // one request: shift first, then coefficients with index 5 at the top
  typedef struct packed {
    logic [ShiftWidth-1:0]         shift;
    logic [Degree:0][CoefW-1:0]    coef;
  } taylor_req_t;

  // one result: shifted coefficients and the saturation flag
  typedef struct packed {
    logic [Degree:0][CoefW-1:0]    coef;
    logic                          ovf;
  } taylor_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [ShiftWidth-1:0]       shift_time_i = '0;
  logic signed [CoefW-1:0]     coef_p0_i = '0;
  logic signed [CoefW-1:0]     coef_p1_i = '0;
  logic signed [CoefW-1:0]     coef_p2_i = '0;
  logic signed [CoefW-1:0]     coef_p3_i = '0;
  logic signed [CoefW-1:0]     coef_p4_i = '0;
  logic signed [CoefW-1:0]     coef_p5_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [CoefW-1:0]     shifted_p0_o;
  logic signed [CoefW-1:0]     shifted_p1_o;
  logic signed [CoefW-1:0]     shifted_p2_o;
  logic signed [CoefW-1:0]     shifted_p3_o;
  logic signed [CoefW-1:0]     shifted_p4_o;
  logic signed [CoefW-1:0]     shifted_p5_o;
  logic                        overflow_o;

  polynomial_taylor_shift #(
    .CoefWidth(CoefW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .shift_time_i (shift_time_i),
    .coef_p0_i    (coef_p0_i),
    .coef_p1_i    (coef_p1_i),
    .coef_p2_i    (coef_p2_i),
    .coef_p3_i    (coef_p3_i),
    .coef_p4_i    (coef_p4_i),
    .coef_p5_i    (coef_p5_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .shifted_p0_o (shifted_p0_o),
    .shifted_p1_o (shifted_p1_o),
    .shifted_p2_o (shifted_p2_o),
    .shifted_p3_o (shifted_p3_o),
    .shifted_p4_o (shifted_p4_o),
    .shifted_p5_o (shifted_p5_o),
    .overflow_o   (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // requests waiting to be driven, and predicted results waiting for the block
  taylor_req_t request_q[$];
  taylor_res_t shifted_q[$];

  // request as it sits on the ports, result as it sits on the ports
  taylor_req_t port_req;
  taylor_res_t port_res;
  assign port_req = {shift_time_i, coef_p5_i, coef_p4_i, coef_p3_i, coef_p2_i, coef_p1_i,
                     coef_p0_i};
  assign port_res = {shifted_p5_o, shifted_p4_o, shifted_p3_o, shifted_p2_o, shifted_p1_o,
                     shifted_p0_o, overflow_o};

  wire req_fire = in_valid_i && !in_stall_o;
  wire res_fire = out_valid_o && !out_stall_i;

  int mismatches;
  int requests_taken;
  int results_seen;
  int overflow_seen;
  int zero_shift_seen;
  int stuck_cycles;

  // near the end of the run both sides go flat out
  wire calm = request_q.size() < CalmTail;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // clamp to a signed range of the given width, noting any clamp
  function automatic longint saturate(input longint v, input int bits, inout bit ovf);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // repeated horner: b[k] += s * b[k+1], product rounded half up to q16.16,
  // saturating accumulator, then clamp to the coefficient range
  function automatic taylor_res_t predict_shift(input taylor_req_t r);
    longint      acc [0:Degree];
    longint      s;
    longint      prod;
    longint      v;
    bit          ovf;
    taylor_res_t res;
    ovf = 1'b0;
    s = longint'(r.shift);
    for (int k = 0; k <= Degree; k++) begin
      acc[k] = longint'($signed(r.coef[k]));
    end
    for (int i = 0; i < Degree; i++) begin
      for (int k = Degree - 1; k >= i; k--) begin
        // arithmetic shift of the signed product gives the floor
        prod = (acc[k + 1] * s + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
        acc[k] = saturate(acc[k] + prod, AccBits, ovf);
      end
    end
    for (int k = 0; k <= Degree; k++) begin
      v = saturate(acc[k], CoefW, ovf);
      res.coef[k] = CoefW'(v);
    end
    res.ovf = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_request(input logic [ShiftWidth-1:0] s,
                                      input logic [CoefW-1:0] c0, input logic [CoefW-1:0] c1,
                                      input logic [CoefW-1:0] c2, input logic [CoefW-1:0] c3,
                                      input logic [CoefW-1:0] c4, input logic [CoefW-1:0] c5);
    taylor_req_t r;
    r.shift = s;
    r.coef  = {c5, c4, c3, c2, c1, c0};
    request_q.insert(request_q.size(), r);
  endfunction

  // mostly short shifts as a trajectory would use, some full range and corners
  function automatic logic [ShiftWidth-1:0] rand_shift();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return ShiftWidth'(1);
          2: return ShiftWidth'(1) << FracBits;
          default: return '1;
        endcase
      end
      1, 2: return ShiftWidth'($urandom);
      default: return ShiftWidth'($urandom_range(0, 32'h3ffff));
    endcase
  endfunction

  // moderate coefficients most of the time, full-width and range ends the rest
  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return {1'b0, {(CoefW-1){1'b1}}};
          1: return {1'b1, {(CoefW-1){1'b0}}};
          2: return '1;
          3: return CoefW'(1);
          default: return '0;
        endcase
      end
      1, 2, 3: return CoefW'({$urandom, $urandom});
      default: return CoefW'(int'($urandom_range(0, 32'h200000)) - 32'sh100000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued requests, idles in random bursts
  // ---------------------------------------------------------------------------

  int send_gap;
  int send_idle_pct;
  int send_phase;
  taylor_req_t next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      shift_time_i <= '0;
      coef_p0_i    <= '0;
      coef_p1_i    <= '0;
      coef_p2_i    <= '0;
      coef_p3_i    <= '0;
      coef_p4_i    <= '0;
      coef_p5_i    <= '0;
      send_gap      = 0;
      send_idle_pct = 0;
      send_phase    = 0;
    end else begin
      // request taken at this edge: predict it now
      if (req_fire) begin
        shifted_q.insert(shifted_q.size(), predict_shift(port_req));
        requests_taken++;
        if (port_req.shift == '0) begin
          zero_shift_seen++;
        end
      end
      // idle rate changes now and then, zero in some stretches
      send_phase++;
      if (send_phase % 97 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: send_idle_pct = 0;
          2: send_idle_pct = 6;
          default: send_idle_pct = 30;
        endcase
      end
      // a held request stays put; otherwise decide what goes out next
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0 && !calm) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0 && !calm &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          send_gap = 0;
          next_req = request_q.pop_front();
          in_valid_i   <= 1'b1;
          shift_time_i <= next_req.shift;
          coef_p0_i    <= next_req.coef[0];
          coef_p1_i    <= next_req.coef[1];
          coef_p2_i    <= next_req.coef[2];
          coef_p3_i    <= next_req.coef[3];
          coef_p4_i    <= next_req.coef[4];
          coef_p5_i    <= next_req.coef[5];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls in random bursts, checks each result against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  int recv_gap;
  int recv_stall_pct;
  int recv_phase;
  taylor_res_t want_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      recv_gap       = 0;
      recv_stall_pct = 0;
      recv_phase     = 0;
    end else begin
      if (res_fire) begin
        if (shifted_q.size() == 0) begin
          flag_mismatch("result arrived with no request outstanding");
        end else begin
          want_res = shifted_q.pop_front();
          for (int k = 0; k <= Degree; k++) begin
            if (port_res.coef[k] !== want_res.coef[k]) begin
              flag_mismatch($sformatf("shifted_p%0d got %h, expected %h", k,
                                      port_res.coef[k], want_res.coef[k]));
            end
          end
          if (port_res.ovf !== want_res.ovf) begin
            flag_mismatch($sformatf("overflow got %b, expected %b", port_res.ovf,
                                    want_res.ovf));
          end
          if (want_res.ovf) begin
            overflow_seen++;
          end
        end
        results_seen++;
      end
      recv_phase++;
      if (recv_phase % 89 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: recv_stall_pct = 0;
          2: recv_stall_pct = 8;
          default: recv_stall_pct = 35;
        endcase
      end
      // stall bursts land whether or not a result is showing
      if (calm) begin
        recv_gap = 0;
        out_stall_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        recv_gap = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake means the block is stuck
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_fire || res_fire) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("no handshake for %0d cycles, %0d results still outstanding", StuckLimit,
                 shifted_q.size());
        $display("tb_top failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatches      = 0;
    requests_taken  = 0;
    results_seen    = 0;
    overflow_seen   = 0;
    zero_shift_seen = 0;
    stuck_cycles    = 0;

    // directed: zero shift leaves everything as is
    add_request('0, '0, '0, '0, '0, '0, '0);
    add_request('0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00000001, 32'h12345678,
                32'hffff0000);
    add_request('0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000);
    // largest shift on range ends, saturating everywhere
    add_request('1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff);
    add_request('1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000);
    // unit shift on unit coefficients gives binomial sums
    add_request(24'h010000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                32'h10000);
    // smallest shift, products sit right at the rounding boundary
    add_request(24'h000001, 32'hffff8000, 32'hffff7fff, 32'h00007fff, 32'h00008000,
                32'hffffffff, 32'h00000001);
    add_request(24'h008000, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 32'hffffffff);
    // a lone top coefficient raised to the fifth power of the largest shift
    add_request('1, '0, '0, '0, '0, '0, 32'h00000001);
    // accumulator clamps midway although the terms fight each other
    add_request(24'h7fffff, '0, '0, '0, '0, 32'h80000000, 32'h7fffffff);
    add_request(24'h800000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000);
    // large constant only: nothing moves, no clamp
    add_request('1, 32'h7fffffff, '0, '0, '0, '0, '0);
    // exact cancellation to zero at s = 15
    add_request(24'h0f0000, 32'hfff10000, 32'h00010000, '0, '0, '0, '0);
    // small alternating values with a 2 s shift
    add_request(24'h020000, 32'h00018000, 32'hfffe8000, 32'h00004000, 32'hffffc000,
                32'h00000800, 32'hfffff800);

    for (int n = 0; n < NumRandom; n++) begin
      add_request(rand_shift(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef());
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, taken and answered
    while (request_q.size() != 0 || in_valid_i || shifted_q.size() != 0) begin
      @(posedge clk_i);
    end
    // catch any stray result behind the last one
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests taken, %0d with zero shift; %0d results checked", requests_taken,
             zero_shift_seen, results_seen);
    $display("%0d results carried the overflow flag; %0d mismatches", overflow_seen,
             mismatches);
    if (mismatches == 0 && shifted_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pts_pkg.sv
src/pts_cell.sv
src/pts_out.sv
src/polynomial_taylor_shift.sv
bench/tb_top.sv
